[rtl/mva_pkg.sv]
package mva_pkg;

  localparam int MAX_VOICES = 9;
  localparam int CHANNELS   = 16;
  localparam int AGE_W      = 32;

  localparam int VIDX_W = (MAX_VOICES > 1) ? $clog2(MAX_VOICES) : 1;
  localparam int CIDX_W = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;

  localparam int MODE_W  = 2;
  localparam int CHAN_W  = 4;
  localparam int DATA_W  = 7;
  localparam int VOICE_W = 4;
  localparam int LEVEL_W = 6;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 7;

  typedef enum logic [MODE_W-1:0] {
    MODE_NOTE_OFF = 2'd0,
    MODE_NOTE_ON  = 2'd1,
    MODE_CTRL     = 2'd2,
    MODE_UNUSED   = 2'd3
  } mode_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_VOICES_IN_USE = 2'd0,
    CFG_LOWEST_NOTE   = 2'd1,
    CFG_HIGHEST_NOTE  = 2'd2,
    CFG_NONE          = 2'd3
  } cfg_idx_t;

  localparam logic [DATA_W-1:0] CTRL_VOLUME = 7'd7;

  localparam logic [VOICE_W-1:0] RST_VOICES_IN_USE = 4'd9;
  localparam logic [DATA_W-1:0]  RST_LOWEST_NOTE   = 7'd21;
  localparam logic [DATA_W-1:0]  RST_HIGHEST_NOTE  = 7'd108;
  localparam logic [DATA_W-1:0]  RST_VOLUME        = 7'd127;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_RELEASE,
    ST_ALLOC,
    ST_COMMIT
  } state_t;

  localparam logic [LEVEL_W-1:0] ATTEN_TABLE [128] = '{
    6'd63, 6'd55, 6'd48, 6'd43, 6'd40, 6'd37, 6'd35, 6'd34,
    6'd32, 6'd31, 6'd29, 6'd28, 6'd27, 6'd26, 6'd26, 6'd25,
    6'd24, 6'd23, 6'd23, 6'd22, 6'd21, 6'd21, 6'd20, 6'd20,
    6'd19, 6'd19, 6'd18, 6'd18, 6'd18, 6'd17, 6'd17, 6'd16,
    6'd16, 6'd16, 6'd15, 6'd15, 6'd15, 6'd14, 6'd14, 6'd14,
    6'd13, 6'd13, 6'd13, 6'd13, 6'd12, 6'd12, 6'd12, 6'd12,
    6'd11, 6'd11, 6'd11, 6'd11, 6'd10, 6'd10, 6'd10, 6'd10,
    6'd9,  6'd9,  6'd9,  6'd9,  6'd9,  6'd8,  6'd8,  6'd8,
    6'd8,  6'd8,  6'd8,  6'd7,  6'd7,  6'd7,  6'd7,  6'd7,
    6'd7,  6'd6,  6'd6,  6'd6,  6'd6,  6'd6,  6'd6,  6'd5,
    6'd5,  6'd5,  6'd5,  6'd5,  6'd5,  6'd5,  6'd5,  6'd4,
    6'd4,  6'd4,  6'd4,  6'd4,  6'd4,  6'd4,  6'd3,  6'd3,
    6'd3,  6'd3,  6'd3,  6'd3,  6'd3,  6'd3,  6'd3,  6'd2,
    6'd2,  6'd2,  6'd2,  6'd2,  6'd2,  6'd2,  6'd2,  6'd2,
    6'd1,  6'd1,  6'd1,  6'd1,  6'd1,  6'd1,  6'd1,  6'd1,
    6'd1,  6'd1,  6'd0,  6'd0,  6'd0,  6'd0,  6'd0,  6'd0
  };

endpackage

[rtl/mva_ifs.sv]
interface mva_in_if;
  logic                             valid;
  logic                             ready;
  logic [mva_pkg::MODE_W-1:0]       mode;
  logic [mva_pkg::CHAN_W-1:0]       channel;
  logic [mva_pkg::DATA_W-1:0]       data_first;
  logic [mva_pkg::DATA_W-1:0]       data_second;

  modport source (output valid, mode, channel, data_first, data_second, input ready);
  modport sink   (input valid, mode, channel, data_first, data_second, output ready);
endinterface

interface mva_out_if;
  logic                             valid;
  logic                             ready;
  logic [mva_pkg::VOICE_W-1:0]      voice;
  logic                             key_on;
  logic [mva_pkg::DATA_W-1:0]       note_out;
  logic [mva_pkg::CHAN_W-1:0]       channel_out;
  logic [mva_pkg::LEVEL_W-1:0]      level;
  logic                             stolen;

  modport source (output valid, voice, key_on, note_out, channel_out, level, stolen,
                  input ready);
  modport sink   (input valid, voice, key_on, note_out, channel_out, level, stolen,
                  output ready);
endinterface

[rtl/midi_voice_allocator.sv]
// Channel   Dir  Word
// in_word   in   mode, channel, data_first, data_second
// out_word  out  voice, key_on, note_out, channel_out, level, stolen
// cfg_*     in   cfg_we, cfg_index, cfg_data (write only)
//
// A note event is accepted, then the voices in use are scanned in turn (at least
// one, nine at most; note-ons on the shared age comparator), then committed.
// Control changes, ignored events and unmatched note-offs do not commit.
// Reset is synchronous: voices free, ages zero, volumes 127, registers defaults.
// A result waits in the output register; commit stalls while it is not taken.
module midi_voice_allocator (
  input  logic                                clk,
  input  logic                                rst_n,
  mva_in_if.sink                              in_word,
  mva_out_if.source                           out_word,
  input  logic                                cfg_we,
  input  logic [mva_pkg::CFG_IDX_W-1:0]       cfg_index,
  input  logic [mva_pkg::CFG_DATA_W-1:0]      cfg_data
);

  mva_pkg::state_t state_r, state_nxt;

  logic [mva_pkg::VOICE_W-1:0] voices_cfg_r;
  logic [mva_pkg::DATA_W-1:0]  low_note_r;
  logic [mva_pkg::DATA_W-1:0]  high_note_r;

  logic [mva_pkg::CHAN_W-1:0]  owner_r [mva_pkg::MAX_VOICES];
  logic [mva_pkg::DATA_W-1:0]  held_r  [mva_pkg::MAX_VOICES];
  logic [mva_pkg::AGE_W-1:0]   age_r   [mva_pkg::MAX_VOICES];
  logic [mva_pkg::AGE_W-1:0]   age_ctr_r;
  logic [mva_pkg::DATA_W-1:0]  volume_r [mva_pkg::CHANNELS];

  logic [mva_pkg::CHAN_W-1:0]  ch_r;
  logic [mva_pkg::DATA_W-1:0]  note_r;
  logic [mva_pkg::VOICE_W-1:0] idx_r;
  logic [mva_pkg::VOICE_W-1:0] pick_r;
  logic [mva_pkg::AGE_W-1:0]   best_r;
  logic                        key_on_r;
  logic                        stolen_r;

  logic                        out_valid_r;
  logic [mva_pkg::VOICE_W-1:0] out_voice_r;
  logic                        out_key_on_r;
  logic [mva_pkg::DATA_W-1:0]  out_note_r;
  logic [mva_pkg::CHAN_W-1:0]  out_chan_r;
  logic [mva_pkg::LEVEL_W-1:0] out_level_r;
  logic                        out_stolen_r;

  logic                        in_acc;
  logic                        chan_ok;
  logic                        in_range;
  logic                        start_alloc;
  logic                        start_release;
  logic                        vol_we;
  logic [mva_pkg::VOICE_W-1:0] last_idx;
  logic                        at_last;
  logic [mva_pkg::AGE_W-1:0]   age_cur;
  logic                        cur_free;
  logic                        cur_less;
  logic                        cur_match;
  logic                        out_free;
  logic                        commit;
  logic                        take_pick;
  logic                        scan_adv;
  logic                        set_stolen;
  logic [mva_pkg::AGE_W-1:0]   ctr_inc;

  assign in_word.ready = (state_r == mva_pkg::ST_IDLE);
  assign in_acc        = in_word.valid && in_word.ready;

  assign chan_ok  = ({1'b0, in_word.channel} < (mva_pkg::CHAN_W + 1)'(mva_pkg::CHANNELS));
  assign in_range = (in_word.data_first >= low_note_r) && (in_word.data_first <= high_note_r);

  always_comb begin
    if (voices_cfg_r == '0) begin
      last_idx = '0;
    end else if (voices_cfg_r > mva_pkg::VOICE_W'(mva_pkg::MAX_VOICES)) begin
      last_idx = mva_pkg::VOICE_W'(mva_pkg::MAX_VOICES - 1);
    end else begin
      last_idx = voices_cfg_r - 1'b1;
    end
  end

  assign at_last   = (idx_r == last_idx);
  assign age_cur   = age_r[idx_r[mva_pkg::VIDX_W-1:0]];
  assign cur_free  = (age_cur == '0);
  assign cur_less  = (idx_r == '0) || (age_cur < best_r);
  assign cur_match = !cur_free && (owner_r[idx_r[mva_pkg::VIDX_W-1:0]] == ch_r)
                     && (held_r[idx_r[mva_pkg::VIDX_W-1:0]] == note_r);
  assign out_free  = !out_valid_r || out_word.ready;
  assign ctr_inc   = (&age_ctr_r) ? age_ctr_r : age_ctr_r + mva_pkg::AGE_W'(1);

  always_comb begin
    state_nxt     = state_r;
    start_alloc   = 1'b0;
    start_release = 1'b0;
    vol_we        = 1'b0;
    commit        = 1'b0;
    take_pick     = 1'b0;
    scan_adv      = 1'b0;
    set_stolen    = 1'b0;
    unique case (state_r)
      mva_pkg::ST_IDLE: begin
        if (in_acc && chan_ok) begin
          priority case (in_word.mode)
            mva_pkg::MODE_NOTE_OFF: begin
              start_release = 1'b1;
            end
            mva_pkg::MODE_NOTE_ON: begin
              if (in_word.data_second == '0) begin
                start_release = 1'b1;
              end else if (in_range) begin
                start_alloc = 1'b1;
              end
            end
            mva_pkg::MODE_CTRL: begin
              vol_we = (in_word.data_first == mva_pkg::CTRL_VOLUME);
            end
            default: begin
            end
          endcase
        end
        if (start_release) begin
          state_nxt = mva_pkg::ST_RELEASE;
        end else if (start_alloc) begin
          state_nxt = mva_pkg::ST_ALLOC;
        end
      end
      mva_pkg::ST_RELEASE: begin
        if (cur_match) begin
          take_pick = 1'b1;
          state_nxt = mva_pkg::ST_COMMIT;
        end else if (at_last) begin
          state_nxt = mva_pkg::ST_IDLE;
        end else begin
          scan_adv = 1'b1;
        end
      end
      mva_pkg::ST_ALLOC: begin
        if (cur_free) begin
          take_pick = 1'b1;
          state_nxt = mva_pkg::ST_COMMIT;
        end else begin
          take_pick = cur_less;
          if (at_last) begin
            set_stolen = 1'b1;
            state_nxt  = mva_pkg::ST_COMMIT;
          end else begin
            scan_adv = 1'b1;
          end
        end
      end
      mva_pkg::ST_COMMIT: begin
        if (out_free) begin
          commit    = 1'b1;
          state_nxt = mva_pkg::ST_IDLE;
        end
      end
      default: begin
        state_nxt = mva_pkg::ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= mva_pkg::ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      voices_cfg_r <= mva_pkg::RST_VOICES_IN_USE;
      low_note_r   <= mva_pkg::RST_LOWEST_NOTE;
      high_note_r  <= mva_pkg::RST_HIGHEST_NOTE;
    end else if (cfg_we) begin
      unique case (mva_pkg::cfg_idx_t'(cfg_index))
        mva_pkg::CFG_VOICES_IN_USE: voices_cfg_r <= cfg_data[mva_pkg::VOICE_W-1:0];
        mva_pkg::CFG_LOWEST_NOTE:   low_note_r   <= cfg_data;
        mva_pkg::CFG_HIGHEST_NOTE:  high_note_r  <= cfg_data;
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int v = 0; v < mva_pkg::MAX_VOICES; v++) begin
        owner_r[v] <= '0;
        held_r[v]  <= '0;
        age_r[v]   <= '0;
      end
      for (int c = 0; c < mva_pkg::CHANNELS; c++) begin
        volume_r[c] <= mva_pkg::RST_VOLUME;
      end
      age_ctr_r <= '0;
    end else begin
      if (vol_we) begin
        volume_r[in_word.channel[mva_pkg::CIDX_W-1:0]] <= in_word.data_second;
      end
      if (commit) begin
        if (key_on_r) begin
          owner_r[pick_r[mva_pkg::VIDX_W-1:0]] <= ch_r;
          held_r[pick_r[mva_pkg::VIDX_W-1:0]]  <= note_r;
          age_r[pick_r[mva_pkg::VIDX_W-1:0]]   <= ctr_inc;
          age_ctr_r                            <= ctr_inc;
        end else begin
          owner_r[pick_r[mva_pkg::VIDX_W-1:0]] <= '0;
          held_r[pick_r[mva_pkg::VIDX_W-1:0]]  <= '0;
          age_r[pick_r[mva_pkg::VIDX_W-1:0]]   <= '0;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start_alloc || start_release) begin
      ch_r     <= in_word.channel;
      note_r   <= in_word.data_first;
      key_on_r <= start_alloc;
      stolen_r <= 1'b0;
      idx_r    <= '0;
    end else begin
      if (scan_adv) begin
        idx_r <= idx_r + 1'b1;
      end
      if (set_stolen) begin
        stolen_r <= 1'b1;
      end
    end
    if (take_pick) begin
      pick_r <= idx_r;
      best_r <= age_cur;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (commit) begin
      out_valid_r <= 1'b1;
    end else if (out_word.ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (commit) begin
      out_voice_r  <= pick_r;
      out_key_on_r <= key_on_r;
      out_note_r   <= note_r;
      out_chan_r   <= ch_r;
      out_level_r  <= key_on_r ? mva_pkg::ATTEN_TABLE[volume_r[ch_r[mva_pkg::CIDX_W-1:0]]]
                               : '0;
      out_stolen_r <= key_on_r && stolen_r;
    end
  end

  assign out_word.valid       = out_valid_r;
  assign out_word.voice       = out_voice_r;
  assign out_word.key_on      = out_key_on_r;
  assign out_word.note_out    = out_note_r;
  assign out_word.channel_out = out_chan_r;
  assign out_word.level       = out_level_r;
  assign out_word.stolen      = out_stolen_r;

endmodule

[tb/mva_checker.sv]
`timescale 1ns / 100ps

module mva_checker
  import mva_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst_n,
  mva_in_if                     in_mon,
  mva_out_if                    out_mon,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data,
  output int                    errors,
  output int                    pending
);

  typedef struct packed {
    logic [VOICE_W-1:0] voice;
    logic               key_on;
    logic [DATA_W-1:0]  note;
    logic [CHAN_W-1:0]  chan;
    logic [LEVEL_W-1:0] level;
    logic               stolen;
  } key_event_t;

  logic [VOICE_W-1:0] voice_limit;
  logic [DATA_W-1:0]  note_lo;
  logic [DATA_W-1:0]  note_hi;

  logic [CHAN_W-1:0]  owner [MAX_VOICES];
  logic [DATA_W-1:0]  held  [MAX_VOICES];
  logic [AGE_W-1:0]   age   [MAX_VOICES];
  logic [AGE_W-1:0]   age_ctr;
  logic [DATA_W-1:0]  volume [CHANNELS];

  key_event_t awaited_keys [$];
  int         mismatch_total = 0;

  function automatic int scan_span();
    int n;
    n = int'(voice_limit);
    if (n < 1) n = 1;
    if (n > MAX_VOICES) n = MAX_VOICES;
    return n;
  endfunction

  function automatic bit release_voice(logic [CHAN_W-1:0] chan, logic [DATA_W-1:0] note,
                                       output key_event_t ev);
    int n;
    int v;
    bit hit;
    n   = scan_span();
    hit = 0;
    ev  = '0;
    for (v = 0; v < n && !hit; v++) begin
      if (age[v] != 0 && owner[v] == chan && held[v] == note) begin
        owner[v]    = '0;
        held[v]     = '0;
        age[v]      = '0;
        ev.voice    = VOICE_W'(v);
        ev.key_on   = 1'b0;
        ev.note     = note;
        ev.chan     = chan;
        hit         = 1;
      end
    end
    return hit;
  endfunction

  function automatic bit start_voice(logic [CHAN_W-1:0] chan, logic [DATA_W-1:0] note,
                                     output key_event_t ev);
    int n;
    int v;
    int pick;
    bit found;
    logic [AGE_W-1:0] best;
    ev = '0;
    if (note < note_lo || note > note_hi) return 0;
    n     = scan_span();
    pick  = 0;
    found = 0;
    for (v = 0; v < n; v++) begin
      if (!found && age[v] == 0) begin
        pick  = v;
        found = 1;
      end
    end
    if (!found) begin
      best = age[0];
      for (v = 1; v < n; v++) begin
        if (age[v] < best) begin
          best = age[v];
          pick = v;
        end
      end
    end
    if (age_ctr != '1) age_ctr++;
    owner[pick] = chan;
    held[pick]  = note;
    age[pick]   = age_ctr;
    ev.voice    = VOICE_W'(pick);
    ev.key_on   = 1'b1;
    ev.note     = note;
    ev.chan     = chan;
    ev.level    = ATTEN_TABLE[volume[chan]];
    ev.stolen   = !found;
    return 1;
  endfunction

  function automatic bit next_key_event(mode_t mode, logic [CHAN_W-1:0] chan,
                                        logic [DATA_W-1:0] d1, logic [DATA_W-1:0] d2,
                                        output key_event_t ev);
    ev = '0;
    if (int'(chan) >= CHANNELS) return 0;
    case (mode)
      MODE_NOTE_OFF: return release_voice(chan, d1, ev);
      MODE_NOTE_ON: begin
        if (d2 == 0) return release_voice(chan, d1, ev);
        return start_voice(chan, d1, ev);
      end
      MODE_CTRL: begin
        if (d1 == CTRL_VOLUME) volume[chan] = d2;
        return 0;
      end
      default: return 0;
    endcase
  endfunction

  function automatic void check_field(string name, int unsigned want, int unsigned got);
    if (want != got) begin
      $error("%s: expected %0d, got %0d", name, want, got);
      mismatch_total++;
    end
  endfunction

  always @(posedge clk) begin
    key_event_t ev;
    key_event_t want;
    if (!rst_n) begin
      voice_limit = RST_VOICES_IN_USE;
      note_lo     = RST_LOWEST_NOTE;
      note_hi     = RST_HIGHEST_NOTE;
      age_ctr     = '0;
      for (int v = 0; v < MAX_VOICES; v++) begin
        owner[v] = '0;
        held[v]  = '0;
        age[v]   = '0;
      end
      for (int c = 0; c < CHANNELS; c++) volume[c] = RST_VOLUME;
      awaited_keys.delete();
    end else begin
      if (cfg_we) begin
        case (cfg_idx_t'(cfg_index))
          CFG_VOICES_IN_USE: voice_limit = cfg_data[VOICE_W-1:0];
          CFG_LOWEST_NOTE:   note_lo     = cfg_data[DATA_W-1:0];
          CFG_HIGHEST_NOTE:  note_hi     = cfg_data[DATA_W-1:0];
          default: ;
        endcase
      end
      if (out_mon.valid && out_mon.ready) begin
        if (awaited_keys.size() == 0) begin
          $error("voice %0d key_on %0d note %0d: no key event awaited",
                 out_mon.voice, out_mon.key_on, out_mon.note_out);
          mismatch_total++;
        end else begin
          want = awaited_keys.pop_front();
          check_field("voice", 32'(want.voice), 32'(out_mon.voice));
          check_field("key_on", 32'(want.key_on), 32'(out_mon.key_on));
          check_field("note_out", 32'(want.note), 32'(out_mon.note_out));
          check_field("channel_out", 32'(want.chan), 32'(out_mon.channel_out));
          check_field("level", 32'(want.level), 32'(out_mon.level));
          check_field("stolen", 32'(want.stolen), 32'(out_mon.stolen));
        end
      end
      if (in_mon.valid && in_mon.ready) begin
        if (next_key_event(mode_t'(in_mon.mode), in_mon.channel, in_mon.data_first,
                           in_mon.data_second, ev))
          awaited_keys.push_back(ev);
      end
    end
    errors  <= mismatch_total;
    pending <= awaited_keys.size();
  end

endmodule

[tb/tb.sv]
`timescale 1ns / 100ps

module tb;
  import mva_pkg::*;

  localparam int SCAN_SETTLE    = 16;
  localparam int HOLD_CYCLES    = 300;
  localparam int WATCHDOG_LIMIT = 4000;
  localparam int PHASE_WORDS    = 73;
  localparam int PHASES         = 10;

  logic                  clk;
  logic                  rst_n;
  logic                  cfg_we;
  logic [CFG_IDX_W-1:0]  cfg_index;
  logic [CFG_DATA_W-1:0] cfg_data;
  int                    errors;
  int                    pending;
  bit                    hold_req;
  int                    burst_left = 0;
  logic [CHAN_W+DATA_W-1:0] sounding [$];

  mva_in_if  in_ch ();
  mva_out_if out_ch ();

  midi_voice_allocator dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_word   (in_ch),
    .out_word  (out_ch),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  mva_checker chk (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_mon    (in_ch),
    .out_mon   (out_ch),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .errors    (errors),
    .pending   (pending)
  );

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  task automatic send_word(mode_t mode, logic [CHAN_W-1:0] chan, logic [DATA_W-1:0] d1,
                           logic [DATA_W-1:0] d2);
    int gap;
    in_ch.valid       <= 1'b1;
    in_ch.mode        <= mode;
    in_ch.channel     <= chan;
    in_ch.data_first  <= d1;
    in_ch.data_second <= d2;
    do @(posedge clk); while (!in_ch.ready);
    if (burst_left > 0) begin
      burst_left--;
    end else begin
      burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(20, 60) : $urandom_range(0, 8);
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 20);
      if (gap > 0) begin
        in_ch.valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
    end
  endtask

  // hold until every awaited key event is out and the scan has finished
  task automatic settle();
    in_ch.valid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (SCAN_SETTLE) @(posedge clk);
  endtask

  task automatic write_reg(cfg_idx_t idx, logic [CFG_DATA_W-1:0] val);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    @(posedge clk);
    cfg_we    <= 1'b0;
    @(posedge clk);
  endtask

  task automatic send_random(logic [DATA_W-1:0] lo, logic [DATA_W-1:0] hi);
    int pick;
    int idx;
    logic [CHAN_W-1:0] chan;
    logic [DATA_W-1:0] note;
    pick = $urandom_range(0, 99);
    chan = CHAN_W'($urandom_range(0, 15));
    if (pick < 45) begin
      note = (lo <= hi) ? DATA_W'($urandom_range(lo, hi)) : DATA_W'($urandom_range(0, 127));
      send_word(MODE_NOTE_ON, chan, note, DATA_W'($urandom_range(1, 127)));
      sounding.push_back({chan, note});
      if (sounding.size() > 32) void'(sounding.pop_front());
    end else if (pick < 70 && sounding.size() > 0) begin
      idx = $urandom_range(0, sounding.size() - 1);
      {chan, note} = sounding[idx];
      sounding.delete(idx);
      if (pick < 62) send_word(MODE_NOTE_OFF, chan, note, DATA_W'($urandom_range(0, 127)));
      else send_word(MODE_NOTE_ON, chan, note, '0);
    end else if (pick < 80) begin
      send_word(MODE_CTRL, chan, CTRL_VOLUME, DATA_W'($urandom_range(0, 127)));
    end else if (pick < 86) begin
      send_word(MODE_CTRL, chan, DATA_W'($urandom_range(0, 127)),
                DATA_W'($urandom_range(0, 127)));
    end else if (pick < 90) begin
      send_word(MODE_UNUSED, chan, DATA_W'($urandom_range(0, 127)),
                DATA_W'($urandom_range(0, 127)));
    end else begin
      send_word(mode_t'(MODE_W'($urandom_range(0, 3))), chan, DATA_W'($urandom_range(0, 127)),
                DATA_W'($urandom_range(0, 127)));
    end
  endtask

  initial begin
    int cyc;
    int stall_style;
    bit hold_done;
    cyc         = 0;
    stall_style = 0;
    hold_done   = 1'b0;
    out_ch.ready <= 1'b0;
    forever begin
      @(posedge clk);
      cyc++;
      if (cyc % 97 == 0) stall_style = $urandom_range(0, 3);
      if (hold_req && !hold_done) begin
        out_ch.ready <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk);
        hold_done = 1'b1;
      end else begin
        case (stall_style)
          0: out_ch.ready <= 1'b1;
          1: out_ch.ready <= 1'($urandom_range(0, 1));
          2: out_ch.ready <= ($urandom_range(0, 7) == 0);
          default: out_ch.ready <= (cyc % 5 < 2);
        endcase
      end
    end
  end

  initial begin
    int idle;
    idle = 0;
    while (idle < WATCHDOG_LIMIT) begin
      @(posedge clk);
      if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready) || cfg_we) idle = 0;
      else idle++;
    end
    $display("TEST FAILED");
    $finish;
  end

  initial begin
    logic [VOICE_W-1:0] voices;
    logic [DATA_W-1:0]  lo;
    logic [DATA_W-1:0]  hi;
    rst_n             <= 1'b0;
    hold_req          <= 1'b0;
    cfg_we            <= 1'b0;
    cfg_index         <= CFG_VOICES_IN_USE;
    cfg_data          <= '0;
    in_ch.valid       <= 1'b0;
    in_ch.mode        <= MODE_NOTE_OFF;
    in_ch.channel     <= '0;
    in_ch.data_first  <= '0;
    in_ch.data_second <= '0;
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    send_word(MODE_CTRL, 4'd0, CTRL_VOLUME, 7'd0);
    send_word(MODE_NOTE_ON, 4'd0, 7'd21, 7'd127);
    send_word(MODE_NOTE_ON, 4'd15, 7'd108, 7'd1);
    send_word(MODE_NOTE_ON, 4'd2, 7'd20, 7'd64);
    send_word(MODE_NOTE_ON, 4'd2, 7'd109, 7'd64);
    send_word(MODE_NOTE_ON, 4'd3, 7'd0, 7'd127);
    send_word(MODE_NOTE_ON, 4'd3, 7'd127, 7'd127);
    send_word(MODE_NOTE_OFF, 4'd15, 7'd108, 7'd127);
    send_word(MODE_NOTE_OFF, 4'd15, 7'd108, 7'd0);
    send_word(MODE_NOTE_ON, 4'd0, 7'd21, 7'd0);
    send_word(MODE_UNUSED, 4'd5, 7'd60, 7'd60);
    send_word(MODE_CTRL, 4'd0, 7'd8, 7'd127);
    for (int k = 0; k < 10; k++) send_word(MODE_NOTE_ON, 4'(k), 7'(40 + k), 7'd100);
    send_word(MODE_NOTE_ON, 4'd9, 7'd127, 7'd127);

    for (int p = 0; p < PHASES; p++) begin
      case (p)
        0: begin voices = 4'd9;  lo = 7'd21;  hi = 7'd108; end
        1: begin voices = 4'd1;  lo = 7'd0;   hi = 7'd127; end
        2: begin voices = 4'd0;  lo = 7'd0;   hi = 7'd127; end
        3: begin voices = 4'd15; lo = 7'd0;   hi = 7'd127; end
        4: begin voices = 4'd4;  lo = 7'd60;  hi = 7'd72;  end
        5: begin voices = 4'd9;  lo = 7'd0;   hi = 7'd127; end
        6: begin voices = 4'd2;  lo = 7'd127; hi = 7'd127; end
        7: begin voices = 4'd9;  lo = 7'd100; hi = 7'd20;  end
        8: begin voices = 4'd9;  lo = 7'd0;   hi = 7'd0;   end
        default: begin
          voices = VOICE_W'($urandom_range(0, 15));
          lo     = DATA_W'($urandom_range(0, 64));
          hi     = DATA_W'($urandom_range(lo, 127));
        end
      endcase
      settle();
      write_reg(CFG_VOICES_IN_USE, CFG_DATA_W'(voices));
      write_reg(CFG_LOWEST_NOTE, lo);
      write_reg(CFG_HIGHEST_NOTE, hi);
      if (p == 5) write_reg(CFG_NONE, CFG_DATA_W'($urandom_range(0, 127)));
      if (p == 3) hold_req <= 1'b1;
      for (int i = 0; i < PHASE_WORDS; i++) begin
        send_random(lo, hi);
        if ($urandom_range(0, 59) == 0) settle();
      end
    end

    settle();
    if (pending != 0) $error("%0d key events never arrived", pending);
    if (errors == 0 && pending == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule

[midi_voice_allocator.f]
rtl/mva_pkg.sv
rtl/mva_ifs.sv
rtl/midi_voice_allocator.sv
tb/mva_checker.sv
tb/tb.sv
